@@ rtl/interval_set_subtract_assert.svh @@
`ifndef INTERVAL_SET_SUBTRACT_ASSERT_SVH
`define INTERVAL_SET_SUBTRACT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ISS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ISS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/iss_pkg.sv @@
package iss_pkg;

    localparam int IDX_W = 11;
    typedef logic [IDX_W-1:0] idx_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_FULL_START = 2'd0;
    localparam cfg_index_t CFG_FULL_END   = 2'd1;

    // Request function codes.
    localparam logic FUNC_RELOAD = 1'b0;

    typedef struct packed {
        logic func;
        idx_t cut_start;
        idx_t cut_end;
    } in_req_t;

    typedef struct packed {
        idx_t area_start;
        idx_t area_end;
        logic area_valid;
        logic overflow;
        logic last;
    } out_req_t;

    // One stored interval, half open.
    typedef struct packed {
        idx_t lo;
        idx_t hi;
    } area_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_SPLIT2,
        S_EMIT_FETCH,
        S_EMIT_LOAD,
        S_EMIT
    } state_t;

endpackage

@@ rtl/interval_set_subtract.sv @@
// Interval table with range removal. A request either reloads the table with the single
// interval [full_start, full_end) or removes the range [cut_start, cut_end) from every
// stored interval, trimming, splitting or deleting entries as needed; the complete table
// is then returned, one interval per result request, with last set on the final one (an
// empty table gives a single result with area_valid low). A remove request walks the
// stored intervals and writes the survivors into the other bank through the single write
// port of the table memory, at most one entry per cycle; a reload writes its one interval
// directly. Results are then delivered one per cycle while the consumer does not stall.
// New requests are taken only once the last result of the previous request has been
// delivered.

`include "interval_set_subtract_assert.svh"

module interval_set_subtract #(
    parameter int MAX_AREAS = 16,
    parameter int MAX_LEDS  = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  iss_pkg::cfg_index_t cfg_index,
    input  iss_pkg::idx_t       cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  iss_pkg::in_req_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output iss_pkg::out_req_t   out_data
);

    import iss_pkg::*;

    // Widths: in-bank entry index, entry count (0..MAX_AREAS), memory address (two banks).
    localparam int IW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
    localparam int CW = $clog2(MAX_AREAS + 1);
    localparam int AW = $clog2(2 * MAX_AREAS);
    localparam int SW = CW + 1;
    localparam int DEPTH = 2 * MAX_AREAS;

    // The table lives in one memory split into two banks. A remove request reads the
    // current bank from the last entry down and writes the surviving intervals into the
    // other bank, also from the top down, so the new table always ends at the top of its
    // bank and starts at MAX_AREAS - count. Because reads and writes of one walk always
    // hit different banks, no forwarding is needed between them.
    area_t mem [DEPTH];
    area_t rd_data_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    area_t             mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    // Configuration registers; a new value takes effect at the next reload.
    idx_t full_start_reg;
    idx_t full_end_reg;

    // Control state.
    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           bank_reg, bank_next;
    logic           pristine_reg, pristine_next;
    logic [IW-1:0]  p_reg, p_next;
    logic [CW-1:0]  run_reg, run_next;
    logic [CW-1:0]  outc_reg, outc_next;
    logic [CW-1:0]  eidx_reg, eidx_next;
    logic           out_valid_reg, out_valid_next;

    // Payload state.
    idx_t     cs_reg, cs_next;
    idx_t     ce_reg, ce_next;
    logic     ovf_reg, ovf_next;
    area_t    hold_reg, hold_next;
    out_req_t out_reg, out_next;

    logic  walk_done;
    logic  emit_load;
    logic  split_go;
    area_t ent;
    idx_t  s;
    idx_t  e;
    logic  trim_start;
    logic  trim_end;
    logic  split_hit;
    logic  del_hit;

    function automatic logic [AW-1:0] mem_addr(input logic bank, input logic [IW-1:0] idx);
        mem_addr = bank ? (AW'(idx) + AW'(MAX_AREAS)) : AW'(idx);
    endfunction

    // Position within a bank of table entry pos, for a table of cnt entries.
    function automatic logic [IW-1:0] tbl_idx(input logic [CW-1:0] cnt,
                                              input logic [CW-1:0] pos);
        tbl_idx = IW'(CW'(MAX_AREAS) - cnt + pos);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_start_reg <= '0;
            full_end_reg   <= idx_t'(MAX_LEDS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FULL_START: full_start_reg <= cfg_data;
                CFG_FULL_END:   full_end_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Until the first request completes, the table is the reset table, which holds one
    // interval that is never written into the memory; it is supplied here instead.
    assign ent = pristine_reg ? area_t'{lo: '0, hi: idx_t'(MAX_LEDS)} : rd_data_reg;
    assign s   = ent.lo;
    assign e   = ent.hi;

    // Removal rules, tested in priority order on the entry as it was read.
    assign trim_start = (cs_reg <= s) && (ce_reg >= s) && (ce_reg < e);
    assign trim_end   = (ce_reg >= e) && (cs_reg <= e) && (cs_reg > s);
    assign split_hit  = (cs_reg > s) && (ce_reg < e);
    assign del_hit    = (cs_reg <= s) && (ce_reg >= e);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= CW'(1);
            bank_reg      <= 1'b0;
            pristine_reg  <= 1'b1;
            p_reg         <= '0;
            run_reg       <= '0;
            outc_reg      <= '0;
            eidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bank_reg      <= bank_next;
            pristine_reg  <= pristine_next;
            p_reg         <= p_next;
            run_reg       <= run_next;
            outc_reg      <= outc_next;
            eidx_reg      <= eidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cs_reg   <= cs_next;
        ce_reg   <= ce_next;
        ovf_reg  <= ovf_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bank_next      = bank_reg;
        pristine_next  = pristine_reg;
        p_next         = p_reg;
        run_next       = run_reg;
        outc_next      = outc_reg;
        eidx_next      = eidx_reg;
        out_valid_next = out_valid_reg;
        cs_next        = cs_reg;
        ce_next        = ce_reg;
        ovf_next       = ovf_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        walk_done      = 1'b0;
        emit_load      = 1'b0;
        split_go       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cs_next  = in_data.cut_start;
                    ce_next  = in_data.cut_end;
                    ovf_next = 1'b0;
                    if (in_data.func == FUNC_RELOAD)
                    begin
                        // The reloaded interval goes to the top of the other bank.
                        mem_we        = 1'b1;
                        mem_waddr     = mem_addr(!bank_reg, IW'(MAX_AREAS - 1));
                        mem_wdata     = area_t'{lo: full_start_reg, hi: full_end_reg};
                        bank_next     = !bank_reg;
                        cnt_next      = CW'(1);
                        pristine_next = 1'b0;
                        eidx_next     = '0;
                        state_next    = S_EMIT_FETCH;
                    end
                    else if (cnt_reg == '0)
                    begin
                        eidx_next  = '0;
                        state_next = S_EMIT_FETCH;
                    end
                    else
                    begin
                        p_next     = IW'(cnt_reg - 1'b1);
                        run_next   = cnt_reg;
                        outc_next  = '0;
                        state_next = S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                mem_re     = 1'b1;
                mem_raddr  = mem_addr(bank_reg, tbl_idx(cnt_reg, CW'(p_reg)));
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                // Prefetch the next lower entry while this one is resolved; it lands in the
                // read register in time for the next visit to this state.
                if (p_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = mem_addr(bank_reg, tbl_idx(cnt_reg, CW'(p_reg - 1'b1)));
                end
                mem_waddr = mem_addr(!bank_reg, IW'(CW'(MAX_AREAS - 1) - outc_reg));
                if (trim_start)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = area_t'{lo: ce_reg, hi: e};
                    outc_next = outc_reg + 1'b1;
                end
                else if (trim_end)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = area_t'{lo: s, hi: cs_reg};
                    outc_next = outc_reg + 1'b1;
                end
                else if (split_hit)
                begin
                    mem_we    = 1'b1;
                    outc_next = outc_reg + 1'b1;
                    if (run_reg >= CW'(MAX_AREAS))
                    begin
                        // No room for a second half: keep the entry as it is.
                        ovf_next  = 1'b1;
                        mem_wdata = ent;
                    end
                    else
                    begin
                        // Upper half first, since the new table is built top down.
                        mem_wdata = area_t'{lo: ce_reg, hi: e};
                        run_next  = run_reg + 1'b1;
                        hold_next = area_t'{lo: s, hi: cs_reg};
                        split_go  = 1'b1;
                    end
                end
                else if (del_hit)
                begin
                    run_next = run_reg - 1'b1;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = ent;
                    outc_next = outc_reg + 1'b1;
                end

                if (split_go)
                begin
                    state_next = S_SPLIT2;
                end
                else if (p_reg == '0)
                begin
                    walk_done = 1'b1;
                end
                else
                begin
                    p_next = p_reg - 1'b1;
                end
            end

            S_SPLIT2:
            begin
                mem_we    = 1'b1;
                mem_waddr = mem_addr(!bank_reg, IW'(CW'(MAX_AREAS - 1) - outc_reg));
                mem_wdata = hold_reg;
                outc_next = outc_reg + 1'b1;
                if (p_reg == '0)
                begin
                    walk_done = 1'b1;
                end
                else
                begin
                    p_next     = p_reg - 1'b1;
                    state_next = S_EVAL;
                end
            end

            S_EMIT_FETCH:
            begin
                if (cnt_reg == '0)
                begin
                    out_next = '{area_start: '0, area_end: '0, area_valid: 1'b0,
                                 overflow: ovf_reg, last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = mem_addr(bank_reg, tbl_idx(cnt_reg, '0));
                    eidx_next  = CW'(1);
                    state_next = S_EMIT_LOAD;
                end
            end

            S_EMIT_LOAD:
            begin
                emit_load = 1'b1;
            end

            S_EMIT:
            begin
                if (!out_stall)
                begin
                    if (out_reg.last)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        emit_load = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // End of a remove walk: the other bank now holds the table.
        if (walk_done)
        begin
            bank_next     = !bank_reg;
            cnt_next      = outc_next;
            pristine_next = 1'b0;
            eidx_next     = '0;
            state_next    = S_EMIT_FETCH;
        end

        // Move the prefetched entry into the output register and fetch the one after it.
        // eidx_reg counts entries already fetched, so the loaded entry is the last one
        // when every entry has been fetched.
        if (emit_load)
        begin
            out_next = '{area_start: rd_data_reg.lo, area_end: rd_data_reg.hi,
                         area_valid: 1'b1, overflow: ovf_reg,
                         last: (eidx_reg == cnt_reg)};
            out_valid_next = 1'b1;
            state_next     = S_EMIT;
            if (eidx_reg != cnt_reg)
            begin
                mem_re    = 1'b1;
                mem_raddr = mem_addr(bank_reg, tbl_idx(cnt_reg, eidx_reg));
                eidx_next = eidx_reg + 1'b1;
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // During a walk, entries not yet visited plus intervals written so far make up the
    // running table size.
    `ISS_ASSERT_IMPL(a_walk_balance, state_reg == S_EVAL,
        SW'(run_reg) == SW'(outc_reg) + SW'(p_reg) + SW'(1), "walk count out of balance")
    `ISS_ASSERT_IMPL(a_size_bound, 1'b1,
        (run_reg <= CW'(MAX_AREAS)) && (cnt_reg <= CW'(MAX_AREAS)), "table size beyond capacity")
    `ISS_ASSERT_IMPL(a_empty_last, out_valid && !out_data.area_valid,
        out_data.last, "empty table result is not the last")
    `ISS_ASSERT_NEXT(a_stream_cont, out_valid && !out_stall && !out_data.last,
        out_valid, "result stream broken before last")
    `ISS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall,
        in_stall, "new request taken while one is in progress")

endmodule

@@ verif/interval_table_checker.sv @@
module interval_table_checker #(
    parameter int MAX_AREAS = 16,
    parameter int MAX_LEDS  = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  iss_pkg::cfg_index_t cfg_index,
    input  iss_pkg::idx_t       cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  iss_pkg::in_req_t    in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  iss_pkg::out_req_t   out_data,
    output int                  outstanding,
    output int                  mismatches,
    output int                  results_checked,
    output int                  full_table_hits,
    output int                  empty_tables
);

    import iss_pkg::*;

    // Shadow copy of the device range registers and of the interval table.
    idx_t     range_lo;
    idx_t     range_hi;
    idx_t     area_lo [MAX_AREAS];
    idx_t     area_hi [MAX_AREAS];
    int       area_count;
    out_req_t expected_areas [$];
    out_req_t want;
    int       errors = 0;
    int       checked = 0;
    int       refusals = 0;
    int       empties = 0;

    // Appends one predicted result request at the tail of the expected queue.
    function automatic void queue_result(out_req_t res);
        expected_areas = {expected_areas, res};
    endfunction

    // Applies one request to the shadow table and queues the table contents it must return.
    function automatic void predict_areas(in_req_t req);
        logic     refused;
        idx_t     s;
        idx_t     e;
        int       p;
        int       k;
        out_req_t res;
        refused = 1'b0;
        if (req.func == FUNC_RELOAD)
        begin
            area_lo[0] = range_lo;
            area_hi[0] = range_hi;
            area_count = 1;
        end
        else
        begin
            // Entries are visited from last to first, each judged on its own old values.
            for (p = area_count - 1; p >= 0; p--)
            begin
                s = area_lo[p];
                e = area_hi[p];
                if (req.cut_start <= s && req.cut_end >= s && req.cut_end < e)
                begin
                    area_lo[p] = req.cut_end;
                end
                else if (req.cut_end >= e && req.cut_start <= e && req.cut_start > s)
                begin
                    area_hi[p] = req.cut_start;
                end
                else if (req.cut_start > s && req.cut_end < e)
                begin
                    if (area_count >= MAX_AREAS)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        for (k = area_count; k > p + 1; k--)
                        begin
                            area_lo[k] = area_lo[k - 1];
                            area_hi[k] = area_hi[k - 1];
                        end
                        area_hi[p]     = req.cut_start;
                        area_lo[p + 1] = req.cut_end;
                        area_hi[p + 1] = e;
                        area_count++;
                    end
                end
                else if (req.cut_start <= s && req.cut_end >= e)
                begin
                    for (k = p; k + 1 < area_count; k++)
                    begin
                        area_lo[k] = area_lo[k + 1];
                        area_hi[k] = area_hi[k + 1];
                    end
                    area_count--;
                end
            end
        end
        if (refused)
            refusals++;
        if (area_count == 0)
        begin
            empties++;
            res          = '0;
            res.overflow = refused;
            res.last     = 1'b1;
            queue_result(res);
        end
        else
        begin
            for (k = 0; k < area_count; k++)
            begin
                res.area_start = area_lo[k];
                res.area_end   = area_hi[k];
                res.area_valid = 1'b1;
                res.overflow   = refused;
                res.last       = (k == area_count - 1);
                queue_result(res);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_lo   = '0;
            range_hi   = idx_t'(MAX_LEDS);
            area_lo[0] = '0;
            area_hi[0] = idx_t'(MAX_LEDS);
            area_count = 1;
            expected_areas.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FULL_START: range_lo = cfg_data;
                    CFG_FULL_END:   range_hi = cfg_data;
                    default:        ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_areas(in_data);
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_areas.size() == 0)
                begin
                    errors++;
                    $display({"%0t: unexpected result, expected none,",
                              " got %0d..%0d v%0b o%0b l%0b"},
                             $time, out_data.area_start, out_data.area_end,
                             out_data.area_valid, out_data.overflow, out_data.last);
                end
                else
                begin
                    want = expected_areas.pop_front();
                    if (out_data !== want)
                    begin
                        errors++;
                        $display({"%0t: area mismatch, expected %0d..%0d v%0b o%0b l%0b,",
                                  " got %0d..%0d v%0b o%0b l%0b"},
                                 $time, want.area_start, want.area_end, want.area_valid,
                                 want.overflow, want.last, out_data.area_start,
                                 out_data.area_end, out_data.area_valid,
                                 out_data.overflow, out_data.last);
                    end
                end
            end
        end
        outstanding     <= expected_areas.size();
        mismatches      <= errors;
        results_checked <= checked;
        full_table_hits <= refusals;
        empty_tables    <= empties;
    end

endmodule

@@ verif/tb_interval_set_subtract.sv @@
// Testbench for the interval table with range removal. The checker module beside the block
// predicts every table dump and compares each result request as it is accepted; this top only
// produces stimulus, idles both channels and reports the verdict.
module tb_interval_set_subtract;

    import iss_pkg::*;

    localparam int MAX_AREAS     = 16;
    localparam int MAX_LEDS      = 1024;
    localparam int HALF_PERIOD   = 10;
    localparam int CLK_PERIOD    = 2 * HALF_PERIOD;
    localparam int RESET_CYCLES  = 7;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 65;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 80;
    localparam int LIMIT_CYCLES  = 500000;

    // The package names only the reload code; the remove code is its complement.
    localparam logic       FUNC_REMOVE = 1'b1;
    // An index that selects no register; writes to it must leave the range alone.
    localparam cfg_index_t CFG_SPARE   = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    idx_t       cfg_data;
    logic       in_valid;
    logic       in_stall;
    in_req_t    in_data;
    logic       out_valid;
    logic       out_stall;
    out_req_t   out_data;

    int outstanding;
    int mismatches;
    int results_checked;
    int full_table_hits;
    int empty_tables;

    // Shared between the stimulus and the result side: a request for one long hold-off,
    // and the quiet flag that switches all idling off for the last part of the run.
    logic hold_request = 1'b0;
    logic quiet = 1'b0;
    int   gap_odds = 0;
    int   requests_sent = 0;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    interval_set_subtract #(
        .MAX_AREAS(MAX_AREAS),
        .MAX_LEDS (MAX_LEDS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    interval_table_checker #(
        .MAX_AREAS(MAX_AREAS),
        .MAX_LEDS (MAX_LEDS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .outstanding    (outstanding),
        .mismatches     (mismatches),
        .results_checked(results_checked),
        .full_table_hits(full_table_hits),
        .empty_tables   (empty_tables)
    );

    // Offers one request and returns at the edge where it is accepted. A random gap may come
    // first; otherwise valid simply stays high from the previous request. Signals are sampled
    // right after the edge, so in_stall holds the value the block presented at that edge.
    task automatic send_request(input logic func, input idx_t cut_lo, input idx_t cut_hi);
        in_req_t req;
        if (!quiet && $urandom_range(0, 99) < gap_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.func      = func;
        req.cut_start = cut_lo;
        req.cut_end   = cut_hi;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    // Stops offering and waits until every predicted result request has been delivered.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Picks one of the boundary positions of the strip.
    function automatic idx_t extreme_index();
        case ($urandom_range(0, 3))
            0:       return idx_t'(0);
            1:       return idx_t'(1);
            2:       return idx_t'(MAX_LEDS - 1);
            default: return idx_t'(MAX_LEDS);
        endcase
    endfunction

    // Random traffic for one register setting. Most of it is carving: a reload followed by
    // a run of narrow cuts, which splits the table until it is full and then refuses splits.
    // Wide cuts trim and delete, and the rest is noise, boundary values and inverted ranges.
    task automatic run_phase(input int budget, input bit with_hold);
        int done;
        int kind;
        int i;
        int len;
        int lo_i;
        int hi_i;
        bit held;
        done = 0;
        held = 1'b0;
        while (done < budget)
        begin
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 10;
                default: gap_odds = 35;
            endcase
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // The cut fields of a reload are ignored, so they carry random values.
                send_request(FUNC_RELOAD, idx_t'($urandom_range(0, MAX_LEDS)),
                             idx_t'($urandom_range(0, MAX_LEDS)));
                done++;
                len = $urandom_range(8, 24);
                for (i = 0; i < len; i++)
                begin
                    lo_i = $urandom_range(0, MAX_LEDS - 1);
                    if ($urandom_range(0, 7) == 0)
                        hi_i = lo_i + $urandom_range(40, 400);
                    else
                        hi_i = lo_i + $urandom_range(1, 40);
                    if (hi_i > MAX_LEDS)
                        hi_i = MAX_LEDS;
                    send_request(FUNC_REMOVE, idx_t'(lo_i), idx_t'(hi_i));
                    done++;
                end
            end
            else if (kind <= 7)
            begin
                // Unrelated bounds, so about half of these ranges are inverted.
                send_request(FUNC_REMOVE, idx_t'($urandom_range(0, MAX_LEDS)),
                             idx_t'($urandom_range(0, MAX_LEDS)));
                done++;
            end
            else if (kind == 8)
            begin
                send_request(FUNC_REMOVE, extreme_index(), extreme_index());
                done++;
            end
            else
            begin
                send_request(($urandom_range(0, 1) == 1) ? FUNC_REMOVE : FUNC_RELOAD,
                             idx_t'($urandom_range(0, MAX_LEDS)),
                             idx_t'($urandom_range(0, MAX_LEDS)));
                done++;
            end
            // Halfway through the phase the result side is asked to hold off for a long
            // stretch while requests keep coming, so the block backs up and stalls its input.
            if (with_hold && !held && done >= budget / 2)
            begin
                hold_request <= 1'b1;
                held = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                pause_until_drained();
            end
        end
    endtask

    // Result side. Stalls come in random bursts, with a density that is redrawn for each window
    // of random length and is sometimes zero; a requested hold-off is counted here.
    initial
    begin : result_side
        int odds;
        int window;
        int held_cycles;
        out_stall <= 1'b0;
        odds   = 0;
        window = 0;
        forever
        begin
            @(posedge clk);
            if (window == 0)
            begin
                window = $urandom_range(50, 200);
                case ($urandom_range(0, 2))
                    0:       odds = 0;
                    1:       odds = 8;
                    default: odds = 30;
                endcase
            end
            window--;
            if (hold_request)
            begin
                hold_request <= 1'b0;
                out_stall    <= 1'b1;
                for (held_cycles = 0; held_cycles < LONG_HOLD; held_cycles++)
                    @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < odds)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int   k;
        int   phase;
        idx_t lo;
        idx_t hi;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_FULL_START;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        gap_odds = 20;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset range [0, 1024).
        send_request(FUNC_RELOAD, 11'd0, 11'd0);
        // Trim at the start, then trim at the end, then split in the middle.
        send_request(FUNC_REMOVE, 11'd0, 11'd10);
        send_request(FUNC_REMOVE, 11'd1000, 11'd1024);
        send_request(FUNC_REMOVE, 11'd100, 11'd200);
        // An empty cut inside an interval still splits it into two touching halves.
        send_request(FUNC_REMOVE, 11'd300, 11'd300);
        // An inverted cut splits every entry into overlapping pieces.
        send_request(FUNC_REMOVE, 11'd600, 11'd50);
        // Cutting the whole strip deletes everything, and a cut on the empty table stays empty.
        send_request(FUNC_REMOVE, 11'd0, 11'd1024);
        send_request(FUNC_REMOVE, 11'd5, 11'd6);
        send_request(FUNC_RELOAD, 11'd1024, 11'd1024);
        // A cut ending exactly at the interval start trims nothing away.
        send_request(FUNC_REMOVE, 11'd0, 11'd0);
        // Fifteen narrow cuts fill the table; the sixteenth split is refused.
        for (k = 0; k < MAX_AREAS; k++)
            send_request(FUNC_REMOVE, idx_t'(k * 64 + 20), idx_t'(k * 64 + 30));
        // Deleting an entry in the middle of a full table moves the later ones down.
        send_request(FUNC_REMOVE, 11'd30, 11'd84);
        pause_until_drained();

        // Random phases, each under its own device range. The block is idle here, so the
        // registers may be written; the new range takes effect at the next reload.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    lo = idx_t'($urandom_range(0, 200));
                    hi = idx_t'($urandom_range(800, MAX_LEDS));
                end
                1:
                begin
                    lo = idx_t'(0);
                    hi = idx_t'(0);
                end
                2:
                begin
                    lo = idx_t'(MAX_LEDS);
                    hi = idx_t'(0);
                end
                3:
                begin
                    lo = idx_t'(MAX_LEDS);
                    hi = idx_t'(MAX_LEDS);
                end
                4:
                begin
                    lo = idx_t'($urandom_range(0, MAX_LEDS));
                    hi = idx_t'($urandom_range(0, MAX_LEDS));
                end
                default:
                begin
                    lo = idx_t'(0);
                    hi = idx_t'(MAX_LEDS);
                end
            endcase
            if (phase == PHASES - 1)
                quiet <= 1'b1;
            cfg_we    <= 1'b1;
            cfg_index <= CFG_FULL_START;
            cfg_data  <= lo;
            @(posedge clk);
            cfg_index <= CFG_FULL_END;
            cfg_data  <= hi;
            @(posedge clk);
            if (phase == 0)
            begin
                cfg_index <= CFG_SPARE;
                cfg_data  <= '1;
                @(posedge clk);
            end
            cfg_we <= 1'b0;
            run_phase(PHASE_ITEMS, phase == 0);
            pause_until_drained();
        end

        // Any result arriving after the table has drained is flagged by the checker.
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("coverage: %0d requests under %0d device ranges, %0d results compared",
                 requests_sent, PHASES + 1, results_checked);
        $display("coverage: %0d requests met a full table on a split, %0d emptied the table",
                 full_table_hits, empty_tables);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

endmodule
